@@ design/masked_aes128_encrypt_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the masked AES-128 block
// Shared property wrappers with clock and synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_AES128_ENCRYPT_ASSERT_SVH
`define MASKED_AES128_ENCRYPT_ASSERT_SVH

// Same-cycle implication
`define MAE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("masked_aes128_encrypt: same-cycle check failed");

// Next-cycle implication
`define MAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("masked_aes128_encrypt: next-cycle check failed");

`endif

@@ design/mae_pkg.sv @@
// ----------------------------------------------------------------------------
// mae_pkg
// Types, constants and GF(2^8) helpers for the masked AES-128 block.
// ----------------------------------------------------------------------------
package mae_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;

  localparam logic [7:0] GF_POLY  = 8'h1B;
  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [3:0] LAST_ROUND = 4'd10;
  localparam logic [7:0] FILL_LAST  = 8'd255;
  localparam logic [7:0] SUB_LAST   = 8'd16;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_ADDK,
    ST_SUB,
    ST_MIX,
    ST_DONE
  } mae_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic fill;
    logic addk;
    logic sub;
    logic mix;
    logic out_load;
    logic cnt_clr;
  } mae_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_last;
    logic sub_last;
    logic round_last;
    logic out_free;
  } mae_status_t;

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
  endfunction

  // MixColumns of one column, row j in bits 8j+7:8j
  function automatic logic [31:0] mix_col(input logic [31:0] v);
    logic [7:0] b0, b1, b2, b3;
    b0 = v[7:0];
    b1 = v[15:8];
    b2 = v[23:16];
    b3 = v[31:24];
    return {xtime(b0) ^ b0 ^ b1 ^ b2 ^ xtime(b3),
            b0 ^ b1 ^ xtime(b2) ^ xtime(b3) ^ b3,
            b0 ^ xtime(b1) ^ xtime(b2) ^ b2 ^ b3,
            xtime(b0) ^ xtime(b1) ^ b1 ^ b2 ^ b3};
  endfunction

  // one AES-128 key schedule step
  function automatic logic [127:0] next_rk(input logic [127:0] rk, input logic [7:0] rcon);
    logic [127:0] nk;
    nk = '0;
    for (int r = 0; r < 4; r++) begin
      nk[8*r +: 8] = SBOX[rk[8*(12 + ((r + 1) % 4)) +: 8]] ^ rk[8*r +: 8];
    end
    nk[7:0] = nk[7:0] ^ rcon;
    for (int c = 1; c < 4; c++) begin
      nk[32*c +: 32] = rk[32*c +: 32] ^ nk[32*(c-1) +: 32];
    end
    return nk;
  endfunction

endpackage

@@ design/mae_if.sv @@
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for plaintext input, ciphertext output and config.
// ----------------------------------------------------------------------------
interface mae_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] plaintext_low;
  logic [63:0] plaintext_high;
  logic [31:0] row_masks;
  logic [7:0]  sbox_in_mask;
  logic [7:0]  sbox_out_mask;

  modport source (output valid, plaintext_low, plaintext_high, row_masks,
                  sbox_in_mask, sbox_out_mask, input ready);
  modport sink (input valid, plaintext_low, plaintext_high, row_masks,
                sbox_in_mask, sbox_out_mask, output ready);
endinterface

interface mae_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] ciphertext_low;
  logic [63:0] ciphertext_high;

  modport source (output valid, ciphertext_low, ciphertext_high, input ready);
  modport sink (input valid, ciphertext_low, ciphertext_high, output ready);
endinterface

interface mae_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/mae_ctrl.sv @@
// ----------------------------------------------------------------------------
// mae_ctrl
// Phase sequencer: S-box fill, key add, byte-serial SubBytes, MixColumns.
// ----------------------------------------------------------------------------
module mae_ctrl import mae_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  mae_status_t status,
  output mae_cmd_t    cmd
);

  mae_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_FILL;
      ST_FILL: if (status.fill_last) state_nxt = ST_ADDK;
      ST_ADDK: state_nxt = status.round_last ? ST_DONE : ST_SUB;
      ST_SUB:  if (status.sub_last) state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_ADDK;
      ST_DONE: if (status.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cmd.cnt_clr = in_valid;
      end
      ST_FILL: cmd.fill = 1'b1;
      ST_ADDK: begin
        cmd.addk = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      ST_SUB:  cmd.sub = 1'b1;
      ST_MIX:  cmd.mix = 1'b1;
      ST_DONE: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ design/mae_datapath.sv @@
// ----------------------------------------------------------------------------
// mae_datapath
// Masked state, round keys, masked S-box memory and output register.
// ----------------------------------------------------------------------------
module mae_datapath import mae_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  mae_cmd_t       cmd,
  output mae_status_t    status,
  // input payload
  input  logic [63:0]    plaintext_low,
  input  logic [63:0]    plaintext_high,
  input  logic [31:0]    row_masks,
  input  logic [7:0]     sbox_in_mask,
  input  logic [7:0]     sbox_out_mask,
  // config write
  input  logic           cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]    cfg_data,
  // result
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    ciphertext_low,
  output logic [63:0]    ciphertext_high
);

  logic [63:0]  key_low_r, key_high_r;
  logic [127:0] state_r, tmp_r, rk_r, ct_r;
  logic [31:0]  rm_r, mrm_r;
  logic [7:0]   min_r, mout_r, rcon_r;
  logic [3:0]   round_r;
  logic [7:0]   cnt_r;
  logic         out_valid_r;
  logic [7:0]   rd_data_r;
  logic [7:0]   sbox_mem [256];

  logic [3:0]   sub_idx, src_idx, wr_idx;
  logic [127:0] mix_in, mix_out;
  logic         last_round;

  assign last_round = (round_r == LAST_ROUND);

  // ShiftRows source byte for output byte c*4+r
  assign sub_idx = cnt_r[3:0];
  assign src_idx = {sub_idx[3:2] + sub_idx[1:0], sub_idx[1:0]};
  assign wr_idx  = sub_idx - 4'd1;

  // swap S-box output mask for row masks, then MixColumns
  assign mix_in = tmp_r ^ {4{rm_r}} ^ {16{mout_r}};
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mix_out[32*c +: 32] = mix_col(mix_in[32*c +: 32]);
    end
  end

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase counter and round counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      round_r <= '0;
    end else begin
      if (cmd.cnt_clr) cnt_r <= '0;
      else if (cmd.fill || cmd.sub) cnt_r <= cnt_r + 8'd1;
      if (cmd.load) round_r <= '0;
      else if (cmd.addk) round_r <= round_r + 4'd1;
    end
  end

  // masked S-box memory: fill writes, SubBytes reads
  always_ff @(posedge clk) begin
    if (cmd.fill) sbox_mem[cnt_r ^ min_r] <= SBOX[cnt_r] ^ mout_r;
    rd_data_r <= sbox_mem[state_r[8*src_idx +: 8]];
  end

  // cipher state, round key and masks
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      state_r <= {plaintext_high, plaintext_low} ^ {4{mix_col(row_masks)}};
      rk_r    <= {key_high_r, key_low_r};
      rm_r    <= row_masks;
      mrm_r   <= mix_col(row_masks);
      min_r   <= sbox_in_mask;
      mout_r  <= sbox_out_mask;
      rcon_r  <= RCON_INIT;
    end
    if (cmd.addk) begin
      state_r <= state_r ^ rk_r ^
                 (last_round ? {16{mout_r}} : ({4{mrm_r}} ^ {16{min_r}}));
    end
    if (cmd.sub && (cnt_r != 8'd0)) begin
      tmp_r[8*wr_idx +: 8] <= rd_data_r;
    end
    if (cmd.mix) begin
      state_r <= last_round ? tmp_r : mix_out;
      rk_r    <= next_rk(rk_r, rcon_r);
      rcon_r  <= xtime(rcon_r);
    end
    if (cmd.out_load) ct_r <= state_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.fill_last  = (cnt_r == FILL_LAST);
  assign status.sub_last   = (cnt_r == SUB_LAST);
  assign status.round_last = last_round;
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign ciphertext_low  = ct_r[63:0];
  assign ciphertext_high = ct_r[127:64];

endmodule

@@ design/masked_aes128_encrypt.sv @@
// ----------------------------------------------------------------------------
// masked_aes128_encrypt
// First-order masked AES-128 encryption with a per-item masked S-box.
//
//   channel  dir  payload
//   in_ch    in   plaintext_low/high, row_masks, sbox_in_mask, sbox_out_mask
//   out_ch   out  ciphertext_low/high
//   cfg_ch   in   index (0 key_low, 1 key_high), data
//
// An item goes through a load, a rewrite of the masked S-box memory through
// its single write port, the first key add, then 10 rounds (byte-serial S-box
// reads, a MixColumns and key step with MixColumns skipped in the last round,
// a key add) and a move of the ciphertext into the output register.
// The output register frees the core: a new item is taken while a result waits.
// Reset (rst_n low, synchronous) idles the sequencer, clears the keys to zero.
// A stalled result holds the core in its last phase until the register frees.
// ----------------------------------------------------------------------------
module masked_aes128_encrypt import mae_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mae_in_if.sink    in_ch,
  mae_out_if.source out_ch,
  mae_cfg_if.sink   cfg_ch
);

  mae_cmd_t    cmd;
  mae_status_t status;

  // config writes always accepted
  assign cfg_ch.ready = 1'b1;

  mae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mae_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .plaintext_low   (in_ch.plaintext_low),
    .plaintext_high  (in_ch.plaintext_high),
    .row_masks       (in_ch.row_masks),
    .sbox_in_mask    (in_ch.sbox_in_mask),
    .sbox_out_mask   (in_ch.sbox_out_mask),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .ciphertext_low  (out_ch.ciphertext_low),
    .ciphertext_high (out_ch.ciphertext_high)
  );

endmodule

@@ design/mae_checker.sv @@
// ----------------------------------------------------------------------------
// mae_checker
// Port-level checks on handshake and sequencing of the masked AES block.
// ----------------------------------------------------------------------------
`include "masked_aes128_encrypt_assert.svh"

module mae_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [127:0] out_data,
  input logic         cfg_valid,
  input logic         cfg_ready
);

  // a stalled result keeps its data
  `MAE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // one item at a time: busy right after a transfer
  `MAE_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

  // no result can appear the cycle after an input transfer
  `MAE_ASSERT_NEXT(a_no_early_out, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

  // key writes never stall
  `MAE_ASSERT_SAME(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind masked_aes128_encrypt mae_checker u_mae_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.ciphertext_high, out_ch.ciphertext_low}),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready)
);
